>>> design/dqvl_pkg.sv
// shared constants, types and scale table for the dq voltage circle limiter
package dqvl_pkg;

   localparam int DATA_W     = 16;
   localparam int SUM_W      = 32;
   localparam int IDX_W      = 7;
   localparam int FACTOR_W   = 15;
   localparam int FRAC_W     = 15;
   localparam int COARSE_LSB = 24;
   localparam int COARSE_W   = SUM_W - COARSE_LSB;

   localparam int RADIUS     = 30145;
   localparam int BASE_INDEX = 54;
   localparam int TAB_LEN    = 74;

   localparam logic [SUM_W-1:0]    LIMIT_SQ  = SUM_W'(RADIUS * RADIUS);
   localparam logic [IDX_W-1:0]    TAB_LAST  = IDX_W'(TAB_LEN - 1);
   localparam logic [COARSE_W-1:0] BASE_CODE = COARSE_W'(BASE_INDEX);

   localparam logic [FACTOR_W-1:0] SCALE_TAB [TAB_LEN] = '{
      15'd32424, 15'd32091, 15'd31929, 15'd31611, 15'd31302, 15'd31002, 15'd30855,
      15'd30568, 15'd30289, 15'd30017, 15'd29884, 15'd29622, 15'd29368, 15'd29243,
      15'd28998, 15'd28759, 15'd28526, 15'd28412, 15'd28187, 15'd27968, 15'd27753,
      15'd27648, 15'd27441, 15'd27238, 15'd27040, 15'd26942, 15'd26750, 15'd26563,
      15'd26470, 15'd26288, 15'd26110, 15'd25935, 15'd25849, 15'd25679, 15'd25513,
      15'd25350, 15'd25269, 15'd25111, 15'd24955, 15'd24803, 15'd24727, 15'd24579,
      15'd24433, 15'd24361, 15'd24219, 15'd24079, 15'd23942, 15'd23874, 15'd23740,
      15'd23609, 15'd23479, 15'd23415, 15'd23289, 15'd23165, 15'd23042, 15'd22982,
      15'd22863, 15'd22745, 15'd22629, 15'd22572, 15'd22459, 15'd22347, 15'd22292,
      15'd22183, 15'd22075, 15'd21970, 15'd21917, 15'd21813, 15'd21711, 15'd21610,
      15'd21561, 15'd21462, 15'd21365, 15'd21268
   };

   // classified pair handed from front to back
   typedef struct packed {
      logic                     limit;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] q;
      logic signed [DATA_W-1:0] d;
   } mid_item_type;

   // finished pair waiting at the output
   typedef struct packed {
      logic signed [DATA_W-1:0] q;
      logic signed [DATA_W-1:0] d;
   } res_item_type;

   function automatic logic [FACTOR_W-1:0] scale_factor(input logic [IDX_W-1:0] idx);
      logic [FACTOR_W-1:0] f;
      if (idx > TAB_LAST) begin
         f = SCALE_TAB[TAB_LEN-1];
      end else begin
         f = SCALE_TAB[idx];
      end
      return f;
   endfunction

endpackage

>>> design/dqvl_fifo.sv
// small first-word-fall-through queue with occupancy count
module dqvl_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/dqvl_front.sv
// front end: accepts dq pairs, squares them and classifies against the circle
module dqvl_front #(
   parameter int MID_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [dqvl_pkg::DATA_W-1:0]  req_q_in,
   input  logic signed [dqvl_pkg::DATA_W-1:0]  req_d_in,
   input  logic [$clog2(MID_DEPTH+1)-1:0]      mid_count,
   output logic                                mid_push,
   output dqvl_pkg::mid_item_type              mid_data
);

   import dqvl_pkg::*;

   localparam int CNT_W = $clog2(MID_DEPTH + 1);

   logic                     accept;
   logic [CNT_W:0]           used;
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [DATA_W-1:0] q_ff, q_in;
   logic signed [DATA_W-1:0] d_ff, d_in;
   logic [SUM_W-2:0]         qq_ff, qq_in;
   logic [SUM_W-2:0]         dd_ff, dd_in;
   logic signed [SUM_W-1:0]  qq_full, dd_full;
   logic [SUM_W-1:0]         sum;
   logic [COARSE_W-1:0]      idx_raw;
   logic [IDX_W-1:0]         idx_sat;

   // slots held by the queue plus the pair still in the square stage
   assign used     = {1'b0, mid_count} + (CNT_W + 1)'(s1_valid_ff);
   assign req_full = (used >= (CNT_W + 1)'(MID_DEPTH));
   assign accept   = req_push && !req_full;

   assign qq_full     = SUM_W'(req_q_in) * SUM_W'(req_q_in);
   assign dd_full     = SUM_W'(req_d_in) * SUM_W'(req_d_in);
   assign s1_valid_in = accept;
   assign q_in        = req_q_in;
   assign d_in        = req_d_in;
   assign qq_in       = qq_full[SUM_W-2:0];
   assign dd_in       = dd_full[SUM_W-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff  <= q_in;
         d_ff  <= d_in;
         qq_ff <= qq_in;
         dd_ff <= dd_in;
      end
   end

   // unsigned sum cannot overflow, both at -32768 gives exactly 2^31
   assign sum     = {1'b0, qq_ff} + {1'b0, dd_ff};
   assign idx_raw = sum[SUM_W-1:COARSE_LSB] - BASE_CODE;

   always_comb begin
      if (idx_raw > COARSE_W'(TAB_LAST)) begin
         idx_sat = TAB_LAST;
      end else begin
         idx_sat = idx_raw[IDX_W-1:0];
      end
   end

   assign mid_push       = s1_valid_ff;
   assign mid_data.limit = (sum > LIMIT_SQ);
   assign mid_data.idx   = idx_sat;
   assign mid_data.q     = q_ff;
   assign mid_data.d     = d_ff;

endmodule

>>> design/dqvl_back.sv
// back end: table lookup, scaling multiply and truncation toward zero, or pass-through inside the circle
module dqvl_back #(
   parameter int OUT_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            mid_empty,
   input  dqvl_pkg::mid_item_type          mid_data,
   output logic                            mid_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
   output logic                            out_push,
   output dqvl_pkg::res_item_type          out_data
);

   import dqvl_pkg::*;

   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   logic [CNT_W:0]           used;
   logic                     b1_valid_ff, b1_valid_in;
   logic                     b1_limit_ff;
   logic signed [DATA_W-1:0] b1_q_ff, b1_d_ff;
   logic [FACTOR_W-1:0]      b1_factor_ff, b1_factor_in;
   logic                     b2_valid_ff, b2_valid_in;
   logic                     b2_limit_ff;
   logic signed [DATA_W-1:0] b2_q_ff, b2_d_ff;
   logic signed [SUM_W-1:0]  b2_prod_q_ff, b2_prod_q_in;
   logic signed [SUM_W-1:0]  b2_prod_d_ff, b2_prod_d_in;
   logic signed [FACTOR_W:0] factor_s;
   logic signed [SUM_W-1:0]  adj_q, adj_d;

   // output queue slots plus pairs still in the two back stages
   assign used    = {1'b0, out_count} + (CNT_W + 1)'(b1_valid_ff)
                    + (CNT_W + 1)'(b2_valid_ff);
   assign mid_pop = !mid_empty && (used < (CNT_W + 1)'(OUT_DEPTH));

   assign b1_valid_in  = mid_pop;
   assign b1_factor_in = scale_factor(mid_data.idx);

   assign factor_s     = $signed({1'b0, b1_factor_ff});
   assign b2_valid_in  = b1_valid_ff;
   assign b2_prod_q_in = SUM_W'(b1_q_ff) * SUM_W'(factor_s);
   assign b2_prod_d_in = SUM_W'(b1_d_ff) * SUM_W'(factor_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         b1_limit_ff  <= mid_data.limit;
         b1_q_ff      <= mid_data.q;
         b1_d_ff      <= mid_data.d;
         b1_factor_ff <= b1_factor_in;
      end
      if (b1_valid_ff) begin
         b2_limit_ff  <= b1_limit_ff;
         b2_q_ff      <= b1_q_ff;
         b2_d_ff      <= b1_d_ff;
         b2_prod_q_ff <= b2_prod_q_in;
         b2_prod_d_ff <= b2_prod_d_in;
      end
   end

   // bias negatives so the arithmetic shift truncates toward zero
   localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_W) - 1);

   assign adj_q = b2_prod_q_ff + (b2_prod_q_ff[SUM_W-1] ? TRUNC_BIAS : '0);
   assign adj_d = b2_prod_d_ff + (b2_prod_d_ff[SUM_W-1] ? TRUNC_BIAS : '0);

   assign out_push   = b2_valid_ff;
   assign out_data.q = b2_limit_ff ? adj_q[FRAC_W+DATA_W-1:FRAC_W] : b2_q_ff;
   assign out_data.d = b2_limit_ff ? adj_d[FRAC_W+DATA_W-1:FRAC_W] : b2_d_ff;

endmodule

>>> design/dq_voltage_circle_limiter.sv
// path: square stage register, mid queue, the two back stage registers, then the output queue
// throughput: one pair per cycle barring rsp stalls, set by the square stage and scaling multipliers
// the front and back run on credits against their queues, so stalls on the rsp side
// back up into the mid queue and only then raise req_full
// reset: synchronous, clears the queues and stage valids, no payload is cleared
// after reset req_full is low and rsp_empty is high
module dq_voltage_circle_limiter #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [dqvl_pkg::DATA_W-1:0]  req_q_in,
   input  logic signed [dqvl_pkg::DATA_W-1:0]  req_d_in,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [dqvl_pkg::DATA_W-1:0]  rsp_q_out,
   output logic signed [dqvl_pkg::DATA_W-1:0]  rsp_d_out
);

   import dqvl_pkg::*;

   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // front to mid queue
   logic                 mid_push;
   mid_item_type         mid_wr_data;
   mid_item_type         mid_rd_data;
   logic                 mid_pop;
   logic                 mid_empty;
   logic [MID_CNT_W-1:0] mid_count;

   // back to output queue
   logic                 out_push;
   res_item_type         out_wr_data;
   res_item_type         out_rd_data;
   logic                 out_empty;
   logic [OUT_CNT_W-1:0] out_count;

   // front: accept transaction, square both axes, classify and pick the table index
   dqvl_front #(
      .MID_DEPTH (MID_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_q_in  (req_q_in),
      .req_d_in  (req_d_in),
      .mid_count (mid_count),
      .mid_push  (mid_push),
      .mid_data  (mid_wr_data)
   );

   // decoupling queue between classification and scaling
   dqvl_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH ($bits(mid_item_type))
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr_data),
      .pop       (mid_pop),
      .pop_data  (mid_rd_data),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   // back: scale factor lookup, multiply, truncate, or pass the pair through
   dqvl_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rd_data),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_wr_data)
   );

   // result queue, its head is the oldest finished transaction
   dqvl_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH ($bits(res_item_type))
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_data),
      .pop       (rsp_pop),
      .pop_data  (out_rd_data),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign rsp_empty = out_empty;
   assign rsp_q_out = out_rd_data.q;
   assign rsp_d_out = out_rd_data.d;

endmodule

>>> design/dqvl_checker.sv
// port-level checker for the dq voltage circle limiter and its bind
module dqvl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [15:0] rsp_q_out,
   input logic signed [15:0] rsp_d_out
);

   // every result lies inside the limit circle, well below this bound
   localparam logic [31:0] MAG_BOUND = 32'd1073741824;

   logic signed [31:0] q_sq, d_sq;
   logic [31:0]        mag_sum;

   assign q_sq    = 32'(rsp_q_out) * 32'(rsp_q_out);
   assign d_sq    = 32'(rsp_d_out) * 32'(rsp_d_out);
   assign mag_sum = $unsigned(q_sq) + $unsigned(d_sq);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input side full after reset");

   a_result_in_circle: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (mag_sum <= MAG_BOUND))
      else $error("result pair outside the limit circle");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_q_out) && $stable(rsp_d_out)))
      else $error("waiting result changed before pop");

endmodule

bind dq_voltage_circle_limiter dqvl_checker u_checker (.*);

>>> tb/tb_dq_voltage_circle_limiter.sv
// testbench for the dq voltage circle limiter: random and directed dq pairs against a predictor
`timescale 1ns / 1ps

module tb_dq_voltage_circle_limiter;

   localparam int W           = dqvl_pkg::DATA_W;
   localparam int STALL_LIMIT = 2000;   // cycles with no transaction on either side
   localparam int HOLD_CYCLES = 250;    // long receiver hold-off to back the block up
   localparam int DRAIN_TAIL  = 20;     // idle tail after the drain, leaves room for a stray result

   // limit radius and table base for the circle check
   localparam longint RADIUS_SQ  = 64'd30145 * 64'd30145;
   localparam int     GAIN_BASE  = 54;
   localparam int     GAIN_LAST  = 73;

   // per-magnitude gain, Q15, one entry per 2^24 step of the squared magnitude
   localparam int CIRCLE_GAIN [74] = '{
      32424, 32091, 31929, 31611, 31302, 31002, 30855, 30568, 30289, 30017,
      29884, 29622, 29368, 29243, 28998, 28759, 28526, 28412, 28187, 27968,
      27753, 27648, 27441, 27238, 27040, 26942, 26750, 26563, 26470, 26288,
      26110, 25935, 25849, 25679, 25513, 25350, 25269, 25111, 24955, 24803,
      24727, 24579, 24433, 24361, 24219, 24079, 23942, 23874, 23740, 23609,
      23479, 23415, 23289, 23165, 23042, 22982, 22863, 22745, 22629, 22572,
      22459, 22347, 22292, 22183, 22075, 21970, 21917, 21813, 21711, 21610,
      21561, 21462, 21365, 21268
   };

   typedef struct packed {
      logic signed [W-1:0] q;
      logic signed [W-1:0] d;
   } dq_pair_type;

   // expected limited pairs in order of acceptance
   class dq_limit_scoreboard;
      dq_pair_type limited_pairs[$];
      int          mismatches;

      function new();
         mismatches = 0;
      endfunction

      // scale the pair back onto the circle when its magnitude is too large
      function dq_pair_type limit_to_circle(dq_pair_type cmd);
         longint      qs;
         longint      ds;
         longint      mag_sq;
         int          idx;
         int          gain;
         dq_pair_type res;
         qs     = cmd.q;
         ds     = cmd.d;
         mag_sq = qs * qs + ds * ds;
         res    = cmd;
         if (mag_sq > RADIUS_SQ) begin
            idx = int'(mag_sq >> 24) - GAIN_BASE;
            // both inputs at full negative scale land one past the table end
            if (idx > GAIN_LAST) begin
               idx = GAIN_LAST;
            end
            gain  = CIRCLE_GAIN[idx];
            // int division truncates toward zero
            res.q = W'((int'(cmd.q) * gain) / 32768);
            res.d = W'((int'(cmd.d) * gain) / 32768);
         end
         return res;
      endfunction

      function void note_pair(dq_pair_type cmd);
         limited_pairs.push_back(limit_to_circle(cmd));
      endfunction

      function int pending();
         return limited_pairs.size();
      endfunction

      function void check_pair(dq_pair_type got);
         dq_pair_type want;
         if (limited_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected result q=%0d d=%0d", $realtime, got.q, got.d);
            end
            return;
         end
         want = limited_pairs.pop_front();
         if (got.q !== want.q || got.d !== want.d) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result mismatch q exp=%0d got=%0d%s, d exp=%0d got=%0d%s",
                        $realtime, want.q, got.q, (got.q !== want.q) ? " (bad)" : "",
                        want.d, got.d, (got.d !== want.d) ? " (bad)" : "");
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic signed [W-1:0] req_q_in;
   logic signed [W-1:0] req_d_in;
   logic                rsp_empty;
   logic                rsp_pop;
   logic signed [W-1:0] rsp_q_out;
   logic signed [W-1:0] rsp_d_out;

   dq_limit_scoreboard board;

   // knobs shared between the stimulus and the receiver
   bit tx_gaps_on;
   bit rx_gaps_on;
   bit rx_hold_req;

   dq_voltage_circle_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_q_in  (req_q_in),
      .req_d_in  (req_d_in),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_q_out (rsp_q_out),
      .rsp_d_out (rsp_d_out)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // offer one pair at the falling edge, hold it until the block takes it
   task automatic send_pair(input int q, input int d);
      dq_pair_type cmd;
      repeat (pick_gap(tx_gaps_on)) @(negedge clock) req_push <= 1'b0;
      cmd.q = W'(q);
      cmd.d = W'(d);
      @(negedge clock);
      req_push <= 1'b1;
      req_q_in <= cmd.q;
      req_d_in <= cmd.d;
      forever begin
         @(posedge clock);
         if (!req_full) begin
            break;
         end
      end
      board.note_pair(cmd);
   endtask

   // edge values: full or near full scale, zero, plus or minus one, or a random value
   function automatic int pick_extreme();
      case ($urandom_range(0, 6))
         0: return -32768;
         1: return 32767;
         2: return -32767;
         3: return 0;
         4: return -1;
         5: return 1;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // random pair: full range, near the limit circle, small, or at the extremes
   task automatic send_random_pair();
      int r;
      int a;
      int b;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         a = int'($signed(16'($urandom)));
         b = int'($signed(16'($urandom)));
      end else if (r < 70) begin
         // one large component, one moderate, so the sum sits around the radius
         a = $urandom_range(28000, 32767);
         b = $urandom_range(0, 12000);
         if ($urandom_range(0, 1)) a = -a;
         if ($urandom_range(0, 1)) b = -b;
         if ($urandom_range(0, 1)) begin
            r = a;
            a = b;
            b = r;
         end
      end else if (r < 85) begin
         a = int'($urandom_range(0, 4095)) - 2048;
         b = int'($urandom_range(0, 4095)) - 2048;
      end else begin
         a = pick_extreme();
         b = pick_extreme();
      end
      send_pair(a, b);
   endtask

   // receiver: pops with random gaps, honors a long hold-off when asked
   initial begin
      dq_pair_type got;
      rsp_pop = 1'b0;
      wait (!reset);
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock) rsp_pop <= 1'b0;
         end else begin
            repeat (pick_gap(rx_gaps_on)) @(negedge clock) rsp_pop <= 1'b0;
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         forever begin
            @(posedge clock);
            if (!rsp_empty) begin
               break;
            end
         end
         got.q = rsp_q_out;
         got.d = rsp_d_out;
         board.check_pair(got);
      end
   end

   // watchdog: ends the run when neither side has moved for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      wait (!reset);
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   // main stimulus
   initial begin
      board       = new();
      reset       = 1'b1;
      req_push    = 1'b0;
      req_q_in    = '0;
      req_d_in    = '0;
      tx_gaps_on  = 1'b1;
      rx_gaps_on  = 1'b1;
      rx_hold_req = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, extremes, radius boundary, truncation of small negatives
      send_pair(0, 0);
      send_pair(1, 1);
      send_pair(-1, -1);
      send_pair(32767, 0);
      send_pair(0, 32767);
      send_pair(-32768, 0);
      send_pair(0, -32768);
      send_pair(32767, 32767);
      send_pair(-32768, -32768);     // sum of 2^31, index saturates
      send_pair(-32768, -32767);
      send_pair(-32768, 32767);
      send_pair(32767, -32768);
      send_pair(-32767, -32767);
      send_pair(30145, 0);           // exactly on the circle, passes
      send_pair(0, -30145);
      send_pair(30146, 0);           // just outside, first table entry
      send_pair(-30146, 0);
      send_pair(21315, 21315);       // just inside
      send_pair(21316, -21316);      // just outside
      send_pair(30146, -1);          // small negative scales to zero, not -1
      send_pair(-30146, 1);
      send_pair(-1, 32767);

      // random with gaps on both sides
      repeat (500) send_random_pair();

      // back to back on both sides
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      repeat (300) send_random_pair();

      // receiver holds off while the sender keeps offering, so req_full rises
      rx_hold_req = 1'b1;
      repeat (60) send_random_pair();
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;

      // sender waits for every outstanding transaction to drain
      @(negedge clock);
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);

      repeat (520) send_random_pair();
      @(negedge clock);
      req_push <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> dq_voltage_circle_limiter.f
design/dqvl_pkg.sv
design/dqvl_fifo.sv
design/dqvl_front.sv
design/dqvl_back.sv
design/dq_voltage_circle_limiter.sv
design/dqvl_checker.sv
tb/tb_dq_voltage_circle_limiter.sv
